@@ design/gisc_pkg.sv @@
// shared types and constants for the greedy independent-set colouring block
// no dependencies; imported by the controller, the datapath and the top level
package gisc_pkg;

  // fixed field widths
  localparam int ROW_INDEX_W = 5;
  localparam int ROW_BITS_W  = 32;
  localparam int COLOR_W     = 5;
  localparam int MASK_W      = 32;
  localparam int CFG_W       = 6;
  localparam int IN_DATA_W   = 40;
  localparam int OUT_DATA_W  = 40;

  // action codes carried on the input tuser
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_RUN  = 1'b1;

  // commands from controller to datapath
  typedef struct packed {
    logic load;      // write one adjacency row
    logic run;       // clear masks, start the first set
    logic step;      // examine the current vertex
    logic next_set;  // start the following set
  } gisc_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic scan_last;   // current vertex is the last one in use
    logic count_zero;  // no vertices in use
    logic last_set;    // the set on the output is the last one: all vertices are now coloured
  } gisc_status_t;

endpackage

@@ design/gisc_ctrl.sv @@
// controller state machine for the greedy independent-set colouring block
// depends on gisc_pkg for the command and status structs
module gisc_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_action,
  output logic                  in_tready,
  input  logic                  out_tready,
  output logic                  out_tvalid,
  input  gisc_pkg::gisc_status_t status,
  output gisc_pkg::gisc_cmd_t    cmd
);
  import gisc_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   in_fire;
  logic   out_fire;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign in_fire    = in_tvalid && in_tready;
  assign out_fire   = out_valid_r && out_tready;

  // command decode
  always_comb begin
    cmd          = '0;
    cmd.load     = in_fire && (in_action == ACT_LOAD);
    cmd.run      = in_fire && (in_action == ACT_RUN);
    cmd.step     = (state_r == ST_SCAN);
    cmd.next_set = (state_r == ST_EMIT) && out_fire && !status.last_set;
  end

  // state and registered output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_fire && (in_action == ACT_RUN) && !status.count_zero) begin
            state_r <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (status.scan_last) begin
            state_r     <= ST_EMIT;
            out_valid_r <= 1'b1;
          end
        end
        ST_EMIT: begin
          if (out_fire) begin
            out_valid_r <= 1'b0;
            state_r     <= status.last_set ? ST_IDLE : ST_SCAN;
          end
        end
        default: begin
          state_r     <= ST_IDLE;
          out_valid_r <= 1'b0;
        end
      endcase
    end
  end

endmodule

@@ design/gisc_datapath.sv @@
// datapath: adjacency store, set masks, vertex scan and result register
// depends on gisc_pkg for widths and the command and status structs
module gisc_datapath #(
  parameter int MAX_VERTICES = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [gisc_pkg::CFG_W-1:0]         cfg_wr_data,
  input  logic [gisc_pkg::ROW_INDEX_W-1:0]   in_row_index,
  input  logic [gisc_pkg::ROW_BITS_W-1:0]    in_row_bits,
  input  gisc_pkg::gisc_cmd_t                cmd,
  output gisc_pkg::gisc_status_t             status,
  output logic [gisc_pkg::COLOR_W-1:0]       out_color_index,
  output logic [gisc_pkg::MASK_W-1:0]        out_member_mask,
  output logic                               out_last_set
);
  import gisc_pkg::*;

  localparam int VLIMIT = (MAX_VERTICES < 32) ? MAX_VERTICES : 32;
  localparam int VW     = $clog2(VLIMIT);
  localparam int NW     = $clog2(VLIMIT + 1);

  logic [VLIMIT-1:0]  adj_r [VLIMIT];
  logic [CFG_W-1:0]   vertex_count_r;
  logic [VLIMIT-1:0]  assigned_r;
  logic [VLIMIT-1:0]  blocked_r;
  logic [VLIMIT-1:0]  members_r;
  logic [VW-1:0]      v_r;
  logic [COLOR_W-1:0] color_r;
  logic [VLIMIT-1:0]  out_mask_r;
  logic [COLOR_W-1:0] out_color_r;
  logic               out_last_r;

  logic [NW-1:0]      n_active;
  logic [VLIMIT-1:0]  full_mask;
  logic [VLIMIT-1:0]  col_bits;
  logic [VLIMIT-1:0]  nbr_mask;
  logic [VLIMIT-1:0]  v_bit;
  logic               take;
  logic [VLIMIT-1:0]  members_step;
  logic [VLIMIT-1:0]  blocked_step;
  logic [VLIMIT-1:0]  assigned_step;
  logic               scan_last;
  logic               row_ok;

  // vertices in use, saturated to the store size
  always_comb begin
    if (vertex_count_r > CFG_W'(VLIMIT)) begin
      n_active = NW'(VLIMIT);
    end else begin
      n_active = NW'(vertex_count_r);
    end
  end

  always_comb begin
    for (int i = 0; i < VLIMIT; i++) begin
      full_mask[i] = (NW'(i) < n_active);
    end
  end

  // neighbours of the current vertex: its row or its column
  always_comb begin
    for (int i = 0; i < VLIMIT; i++) begin
      col_bits[i] = adj_r[i][v_r];
    end
  end

  assign nbr_mask      = adj_r[v_r] | col_bits;
  assign v_bit         = VLIMIT'(1) << v_r;
  assign take          = !blocked_r[v_r];
  assign members_step  = take ? (members_r | v_bit) : members_r;
  assign blocked_step  = take ? (blocked_r | v_bit | nbr_mask) : blocked_r;
  assign assigned_step = assigned_r | members_step;
  assign scan_last     = ((NW'(v_r) + NW'(1)) == n_active);
  assign row_ok        = ({1'b0, in_row_index} < (ROW_INDEX_W + 1)'(VLIMIT));

  // adjacency store, written one row per load item
  always_ff @(posedge clk) begin
    if (cmd.load && row_ok) begin
      adj_r[in_row_index[VW-1:0]] <= in_row_bits[VLIMIT-1:0];
    end
  end

  // vertex count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vertex_count_r <= CFG_W'(32);
    end else if (cfg_wr_en) begin
      vertex_count_r <= cfg_wr_data;
    end
  end

  // set masks and scan position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      assigned_r <= '0;
      blocked_r  <= '0;
      members_r  <= '0;
      v_r        <= '0;
      color_r    <= '0;
    end else begin
      priority if (cmd.run) begin
        assigned_r <= '0;
        blocked_r  <= '0;
        members_r  <= '0;
        v_r        <= '0;
        color_r    <= '0;
      end else if (cmd.next_set) begin
        blocked_r <= assigned_r;
        members_r <= '0;
        v_r       <= '0;
        color_r   <= color_r + COLOR_W'(1);
      end else if (cmd.step) begin
        blocked_r <= blocked_step;
        members_r <= members_step;
        v_r       <= v_r + VW'(1);
        if (scan_last) begin
          assigned_r <= assigned_step;
        end
      end
    end
  end

  // result register, loaded when a set is complete
  always_ff @(posedge clk) begin
    if (cmd.step && scan_last) begin
      out_mask_r  <= members_step;
      out_color_r <= color_r;
      out_last_r  <= (assigned_step == full_mask);
    end
  end

  assign out_color_index   = out_color_r;
  assign out_member_mask   = MASK_W'(out_mask_r);
  assign out_last_set      = out_last_r;

  assign status.scan_last  = scan_last;
  assign status.count_zero = (vertex_count_r == '0);
  assign status.last_set   = out_last_r;

endmodule

@@ design/greedy_independent_set_coloring.sv @@
// greedy colouring by maximal independent sets; a load item writes one adjacency row
// a run scans one vertex per cycle: each set scans every vertex in use
// (vertex_count capped at the store size), then waits for the output handshake
// one item is worked on at a time; input is taken again once the last set is gone
// synchronous active-low reset: vertex count 32, masks cleared, adjacency undefined
// depends on gisc_pkg, gisc_ctrl and gisc_datapath
module greedy_independent_set_coloring #(
  parameter int MAX_VERTICES = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration: vertex_count
  input  logic                              cfg_wr_en,
  input  logic [gisc_pkg::CFG_W-1:0]        cfg_wr_data,
  // input item
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [gisc_pkg::IN_DATA_W-1:0]    in_tdata,   // row_index[4:0], row_bits[36:5]
  input  logic                              in_tuser,   // action
  // result item
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [gisc_pkg::OUT_DATA_W-1:0]   out_tdata,  // color_index[4:0], member_mask[36:5]
  output logic                              out_tlast   // last_set
);
  import gisc_pkg::*;

  gisc_cmd_t          cmd;
  gisc_status_t       status;
  logic [COLOR_W-1:0] color_index;
  logic [MASK_W-1:0]  member_mask;

  // sequencing
  gisc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_action  (in_tuser),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .status     (status),
    .cmd        (cmd)
  );

  // storage and scan
  gisc_datapath #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_row_index    (in_tdata[ROW_INDEX_W-1:0]),
    .in_row_bits     (in_tdata[ROW_INDEX_W+ROW_BITS_W-1:ROW_INDEX_W]),
    .cmd             (cmd),
    .status          (status),
    .out_color_index (color_index),
    .out_member_mask (member_mask),
    .out_last_set    (out_tlast)
  );

  assign out_tdata = {{(OUT_DATA_W-MASK_W-COLOR_W){1'b0}}, member_mask, color_index};

endmodule

@@ tb/greedy_independent_set_coloring_tb.sv @@
// self-checking testbench for the greedy independent-set colouring block
// drives adjacency rows and run commands and checks every colour set against typed expectations or a built-in predictor
// depends on gisc_pkg and greedy_independent_set_coloring
module greedy_independent_set_coloring_tb;
  import gisc_pkg::*;

  localparam int CYCLE_LIMIT   = 2000000;
  localparam int SETTLE_CYCLES = 40;
  localparam int RANDOM_ITEMS  = 175;
  localparam int PREDICT       = -1;

  // one colour set as it leaves the block
  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic [MASK_W-1:0]  members;
    logic               last;
  } set_result_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  // one line of the directed table; typed_sets of PREDICT leaves the answer to the predictor
  typedef struct packed {
    row_kind_t       kind;
    logic [CFG_W-1:0] count;
    logic            act;
    logic [4:0]      idx;
    logic [31:0]     bits;
    int              typed_sets;
    set_result_t     first_set;
    set_result_t     second_set;
  } stim_row_t;

  localparam set_result_t NONE = '0;

  localparam int DIRECTED_ROWS = 25;
  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    // reset count of 32 on a blank graph: one set holding every vertex
    '{ROW_ITEM, 6'd0,  ACT_RUN,  5'd0,  32'h0,         1,
      '{5'd0, 32'hFFFF_FFFF, 1'b1}, NONE},
    // top vertex joined to everything, itself included
    '{ROW_ITEM, 6'd0,  ACT_LOAD, 5'd31, 32'hFFFF_FFFF, PREDICT, NONE, NONE},
    '{ROW_ITEM, 6'd0,  ACT_RUN,  5'd0,  32'h0,         2,
      '{5'd0, 32'h7FFF_FFFF, 1'b0}, '{5'd1, 32'h8000_0000, 1'b1}},
    // a second run starts from clear masks
    '{ROW_ITEM, 6'd0,  ACT_RUN,  5'd0,  32'h0,         2,
      '{5'd0, 32'h7FFF_FFFF, 1'b0}, '{5'd1, 32'h8000_0000, 1'b1}},
    // no vertices in use: no set at all
    '{ROW_CFG,  6'd0,  ACT_LOAD, 5'd0,  32'h0,         PREDICT, NONE, NONE},
    '{ROW_ITEM, 6'd0,  ACT_RUN,  5'd0,  32'h0,         0,       NONE, NONE},
    // count beyond the array saturates to 32
    '{ROW_CFG,  6'd63, ACT_LOAD, 5'd0,  32'h0,         PREDICT, NONE, NONE},
    '{ROW_ITEM, 6'd0,  ACT_RUN,  5'd0,  32'h0,         2,
      '{5'd0, 32'h7FFF_FFFF, 1'b0}, '{5'd1, 32'h8000_0000, 1'b1}},
    // single vertex: the top row lies outside and is ignored
    '{ROW_CFG,  6'd1,  ACT_LOAD, 5'd0,  32'h0,         PREDICT, NONE, NONE},
    '{ROW_ITEM, 6'd0,  ACT_RUN,  5'd0,  32'h0,         1,
      '{5'd0, 32'h0000_0001, 1'b1}, NONE},
    // edge given by a row bit
    '{ROW_ITEM, 6'd0,  ACT_LOAD, 5'd0,  32'hFFFF_FFFF, PREDICT, NONE, NONE},
    '{ROW_CFG,  6'd2,  ACT_LOAD, 5'd0,  32'h0,         PREDICT, NONE, NONE},
    '{ROW_ITEM, 6'd0,  ACT_RUN,  5'd0,  32'h0,         2,
      '{5'd0, 32'h0000_0001, 1'b0}, '{5'd1, 32'h0000_0002, 1'b1}},
    // same edge given only by a column bit
    '{ROW_ITEM, 6'd0,  ACT_LOAD, 5'd0,  32'h0,         PREDICT, NONE, NONE},
    '{ROW_ITEM, 6'd0,  ACT_LOAD, 5'd1,  32'h0000_0001, PREDICT, NONE, NONE},
    '{ROW_ITEM, 6'd0,  ACT_RUN,  5'd0,  32'h0,         2,
      '{5'd0, 32'h0000_0001, 1'b0}, '{5'd1, 32'h0000_0002, 1'b1}},
    // mixed patterns, left to the predictor
    '{ROW_CFG,  6'd33, ACT_LOAD, 5'd0,  32'h0,         PREDICT, NONE, NONE},
    '{ROW_ITEM, 6'd0,  ACT_LOAD, 5'd16, 32'hAAAA_5555, PREDICT, NONE, NONE},
    '{ROW_ITEM, 6'd0,  ACT_LOAD, 5'd30, 32'h0F0F_F0F0, PREDICT, NONE, NONE},
    '{ROW_ITEM, 6'd0,  ACT_RUN,  5'd0,  32'h0,         PREDICT, NONE, NONE},
    '{ROW_CFG,  6'd3,  ACT_LOAD, 5'd0,  32'h0,         PREDICT, NONE, NONE},
    '{ROW_ITEM, 6'd0,  ACT_LOAD, 5'd2,  32'h0000_0003, PREDICT, NONE, NONE},
    '{ROW_ITEM, 6'd0,  ACT_RUN,  5'd0,  32'h0,         PREDICT, NONE, NONE},
    '{ROW_CFG,  6'd32, ACT_LOAD, 5'd0,  32'h0,         PREDICT, NONE, NONE},
    '{ROW_ITEM, 6'd0,  ACT_RUN,  5'd0,  32'h0,         PREDICT, NONE, NONE}
  };

  logic                  clk;
  logic                  rst_n       = 1'b0;
  logic                  cfg_wr_en   = 1'b0;
  logic [CFG_W-1:0]      cfg_wr_data = '0;
  logic                  in_tvalid   = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata    = '0;  // row_index[4:0], row_bits[36:5]
  logic                  in_tuser    = 1'b0;  // action
  logic                  out_tvalid;
  logic                  out_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;  // color_index[4:0], member_mask[36:5]
  logic                  out_tlast;  // last_set

  // predictor state
  logic [31:0]      vertex_rows [32];
  logic [CFG_W-1:0] vertex_limit = 6'd32;

  set_result_t pending_sets [$];
  set_result_t oldest_set;
  int          cycle_count  = 0;
  int          sent_items   = 0;
  int          checked_sets = 0;
  int          fail_count   = 0;
  logic        steady;

  greedy_independent_set_coloring #(.MAX_VERTICES(32)) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // no random idling on either side inside this window
  assign steady = (cycle_count >= 3000) && (cycle_count < 8000);

  // cycle count and run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d sets outstanding", cycle_count,
               pending_sets.size());
      $display("FAILURE");
      $finish;
    end
  end

  // greedy split into maximal independent sets; loads only update the rows
  function automatic void colour_graph(input logic act, input logic [4:0] idx,
                                       input logic [31:0] bits, output set_result_t sets [$]);
    int          n;
    int          v;
    int          color;
    logic [31:0] full;
    logic [31:0] coloured;
    logic [31:0] blocked;
    logic [31:0] members;
    logic [31:0] nbrs;
    sets = {};
    if (act == ACT_LOAD) begin
      vertex_rows[idx] = bits;
      return;
    end
    n = (vertex_limit > 6'd32) ? 32 : int'(vertex_limit);
    if (n == 0) return;
    full = (n == 32) ? '1 : ((32'd1 << n) - 32'd1);
    coloured = '0;
    color = 0;
    while (coloured != full && color < 32) begin
      blocked = coloured;
      members = '0;
      do begin
        v = -1;
        for (int i = 0; i < n && v < 0; i++) if (!blocked[i]) v = i;
        if (v >= 0) begin
          // neighbours in either direction, clipped to the vertices in use
          nbrs = vertex_rows[v];
          for (int i = 0; i < n; i++) if (vertex_rows[i][v]) nbrs[i] = 1'b1;
          members[v] = 1'b1;
          blocked = blocked | members | (nbrs & full);
        end
      end while (v >= 0);
      coloured = coloured | members;
      sets.push_back('{5'(color), members, coloured == full});
      color++;
    end
  endfunction

  // present one item, wait for the handshake, then record its colour sets
  task automatic offer_item(input logic act, input logic [4:0] idx, input logic [31:0] bits,
                            input bit trust_predictor);
    set_result_t sets [$];
    while (!steady && $urandom_range(0, 99) < 15) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {3'b000, bits, idx};
    do @(posedge clk); while (!in_tready);
    sent_items++;
    colour_graph(act, idx, bits, sets);
    if (trust_predictor) foreach (sets[k]) pending_sets.push_back(sets[k]);
  endtask

  // hold the sender until every set is out and a possible silent run is done
  task automatic settle_block();
    in_tvalid <= 1'b0;
    while (pending_sets.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_count(input logic [CFG_W-1:0] value);
    settle_block();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en    <= 1'b0;
    vertex_limit = value;
  endtask

  // result side: random stalls and field-by-field comparison
  always @(posedge clk) begin
    out_tready <= steady || ($urandom_range(0, 99) >= 15);
    if (rst_n && out_tvalid && out_tready) begin
      checked_sets++;
      if (pending_sets.size() == 0) begin
        $error("colour set with none expected: color_index %0d member_mask %h last_set %b",
               out_tdata[4:0], out_tdata[36:5], out_tlast);
        fail_count++;
      end else begin
        oldest_set = pending_sets.pop_front();
        if (out_tdata[4:0] !== oldest_set.color) begin
          $error("color_index: expected %0d, got %0d", oldest_set.color, out_tdata[4:0]);
          fail_count++;
        end
        if (out_tdata[36:5] !== oldest_set.members) begin
          $error("member_mask: expected %h, got %h", oldest_set.members, out_tdata[36:5]);
          fail_count++;
        end
        if (out_tlast !== oldest_set.last) begin
          $error("last_set: expected %b, got %b", oldest_set.last, out_tlast);
          fail_count++;
        end
      end
    end
  end

  initial begin : stimulus
    logic [CFG_W-1:0] new_count;
    logic [31:0]      bits;
    int               n_used;
    int               shape;
    int               phase;
    int               base;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // blank graph first so that no run ever reads a row that was never written
    for (int v = 0; v < 32; v++) offer_item(ACT_LOAD, 5'(v), 32'h0, 1'b1);

    // directed table
    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      if (DIRECTED[r].kind == ROW_CFG) begin
        write_count(DIRECTED[r].count);
      end else begin
        offer_item(DIRECTED[r].act, DIRECTED[r].idx, DIRECTED[r].bits,
                   DIRECTED[r].typed_sets == PREDICT);
        if (DIRECTED[r].typed_sets > 0) pending_sets.push_back(DIRECTED[r].first_set);
        if (DIRECTED[r].typed_sets > 1) pending_sets.push_back(DIRECTED[r].second_set);
      end
    end

    // random graph phases: new count, some rows, then one or two runs
    base  = sent_items;
    phase = 0;
    while (sent_items - base < RANDOM_ITEMS) begin
      if (phase == 0) begin
        new_count = 6'd32;
      end else if ($urandom_range(0, 7) == 0) begin
        case ($urandom_range(0, 3))
          0: new_count = 6'd0;
          1: new_count = 6'd1;
          2: new_count = 6'd32;
          default: new_count = 6'($urandom_range(33, 63));
        endcase
      end else begin
        new_count = 6'($urandom_range(1, 32));
      end
      write_count(new_count);
      n_used = (new_count > 6'd32) ? 32 : int'(new_count);
      shape  = (phase == 0) ? 0 : $urandom_range(0, 5);
      if (shape == 0) begin
        // complete graph: one set per vertex
        for (int v = 0; v < n_used; v++) offer_item(ACT_LOAD, 5'(v), 32'hFFFF_FFFF, 1'b1);
      end else begin
        repeat ($urandom_range(1, 6)) begin
          case (shape)
            1: bits = $urandom & $urandom & $urandom;
            2: bits = $urandom | $urandom;
            3: bits = $urandom;
            4: bits = 32'd1 << $urandom_range(0, 31);
            default: bits = ($urandom_range(0, 1) == 0) ? 32'h0 : 32'hFFFF_FFFF;
          endcase
          offer_item(ACT_LOAD, 5'($urandom_range(0, 31)), bits, 1'b1);
        end
      end
      repeat ($urandom_range(1, 2)) offer_item(ACT_RUN, 5'($urandom), $urandom, 1'b1);
      phase++;
    end

    settle_block();
    $display("sent %0d items over %0d random graph phases after the directed table",
             sent_items, phase);
    $display("checked %0d colour sets, %0d mismatches", checked_sets, fail_count);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/gisc_pkg.sv
design/gisc_ctrl.sv
design/gisc_datapath.sv
design/greedy_independent_set_coloring.sv
tb/greedy_independent_set_coloring_tb.sv
